// ===== sv/mp2d_pkg.sv =====
// ----------------------------------------------------------------------------
// mp2d_pkg
// Shared constants and types for the streaming 2-D max pooling block.
// ----------------------------------------------------------------------------
package mp2d_pkg;

   // parameter defaults
   localparam int MAX_FRAME_DIM_DEF = 1024;
   localparam int MAX_GRID_DIM_DEF  = 256;
   localparam int SAMPLE_WIDTH_DEF  = 16;

   // register and field widths
   localparam int REG_W      = 11;   // frame and window size registers
   localparam int GREG_W     = 9;    // grid size registers
   localparam int CSR_ADDR_W = 3;
   localparam int POOLED_W   = 15;
   localparam int GRID_IDX_W = 8;
   localparam int RSP_DATA_W = 32;

   // register reset values
   localparam logic [REG_W-1:0]  FRAME_COLS_RST    = REG_W'(1024);
   localparam logic [REG_W-1:0]  FRAME_ROWS_RST    = REG_W'(1024);
   localparam logic [GREG_W-1:0] GRID_COLS_RST     = GREG_W'(256);
   localparam logic [GREG_W-1:0] GRID_ROWS_RST     = GREG_W'(256);
   localparam logic [REG_W-1:0]  WINDOW_WIDTH_RST  = REG_W'(4);
   localparam logic [REG_W-1:0]  WINDOW_HEIGHT_RST = REG_W'(4);

   // register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FRAME_COLS    = 3'd0,
      CSR_FRAME_ROWS    = 3'd1,
      CSR_GRID_COLS     = 3'd2,
      CSR_GRID_ROWS     = 3'd3,
      CSR_WINDOW_WIDTH  = 3'd4,
      CSR_WINDOW_HEIGHT = 3'd5
   } csr_index_type;

   // divider lanes used by the resync pass
   localparam int LANE_FC = 0;   // frame cols / window width
   localparam int LANE_FR = 1;   // frame rows / window height
   localparam int LANE_X  = 2;   // column position / window width
   localparam int LANE_Y  = 3;   // row position / window height
   localparam int NLANE   = 4;

   // resync sequencer
   typedef enum logic [3:0] {
      ST_RUN  = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_FIN  = 4'b1000
   } sync_state_type;

endpackage

// ===== sv/max_pool_2d_stream.sv =====
// ----------------------------------------------------------------------------
// max_pool_2d_stream
// Non-overlapping 2-D max pooling over a raster-order sample stream, with
// one running maximum per grid column held in a row memory.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents (tdata from bit 0 up)         tuser/tlast
//  req_     in   sample (SAMPLE_WIDTH, signed Q8.8)          -
//  rsp_     out  pooled (15), grid_row (8), grid_col (8)     tlast = frame_done
//  csr_     in   csr_we, csr_addr (register index), csr_wdata -
//
//  one sample per cycle sustained while no resync runs and rsp_tready
//  keeps up; a result passes stage 1 (row memory read-modify-write) and
//  the result register; reset and every register write start a resync
//  through LOAD, DIV and FIN, one quotient bit per cycle in four
//  restoring dividers; req_tready stays low meanwhile. With rsp_tready
//  low the result holds; samples closing no window pass on, one closing sample is taken in
// ----------------------------------------------------------------------------
module max_pool_2d_stream #(
   parameter int MAX_FRAME_DIM = mp2d_pkg::MAX_FRAME_DIM_DEF,
   parameter int MAX_GRID_DIM  = mp2d_pkg::MAX_GRID_DIM_DEF,
   parameter int SAMPLE_WIDTH  = mp2d_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    req_tdata,   // sample
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [mp2d_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // pooled, grid_row, grid_col
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [mp2d_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [mp2d_pkg::REG_W-1:0]           csr_wdata
);
   import mp2d_pkg::*;

   localparam int DIM_W  = $clog2(MAX_FRAME_DIM + 1);
   localparam int POS_W  = $clog2(MAX_FRAME_DIM);
   localparam int GDIM_W = $clog2(MAX_GRID_DIM + 1);
   localparam int XW0    = (DIM_W > REG_W) ? DIM_W : REG_W;
   localparam int XW     = (XW0 > GDIM_W) ? XW0 : GDIM_W;
   localparam int CMP_W  = (DIM_W + 1 > XW) ? DIM_W + 1 : XW;
   localparam int GIDX_W = (MAX_GRID_DIM > 1) ? $clog2(MAX_GRID_DIM) : 1;
   localparam int VAL_W  = SAMPLE_WIDTH - 1;
   localparam int CNT_W  = $clog2(DIM_W + 1);

   localparam logic [XW-1:0] MAXF_X = XW'(MAX_FRAME_DIM);
   localparam logic [XW-1:0] MAXG_X = XW'(MAX_GRID_DIM);
   localparam logic [XW-1:0] ONE_X  = XW'(1);

   typedef struct packed {
      logic [VAL_W-1:0]      val;
      logic                  win;
      logic                  first;
      logic                  last;
      logic                  done;
      logic [GIDX_W-1:0]     addr;
      logic [GRID_IDX_W-1:0] grow;
      logic [GRID_IDX_W-1:0] gcol;
   } s1_type;

   // one restoring division step: shift in a dividend bit, subtract if it fits
   function automatic logic [2*DIM_W-1:0] div_step(input logic [DIM_W-1:0] rem,
                                                   input logic [DIM_W-1:0] quo,
                                                   input logic [XW-1:0]    dvs);
      logic [CMP_W-1:0] r2;
      logic [CMP_W-1:0] dx;
      logic             take;
      r2   = CMP_W'({rem, quo[DIM_W-1]});
      dx   = CMP_W'(dvs);
      take = (r2 >= dx);
      if (take) begin
         r2 = r2 - dx;
      end
      return {r2[DIM_W-1:0], quo[DIM_W-2:0], take};
   endfunction

   // configuration registers
   logic [REG_W-1:0]  frame_cols_ff, frame_rows_ff, window_width_ff, window_height_ff;
   logic [GREG_W-1:0] grid_cols_ff, grid_rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_cols_ff    <= FRAME_COLS_RST;
         frame_rows_ff    <= FRAME_ROWS_RST;
         grid_cols_ff     <= GRID_COLS_RST;
         grid_rows_ff     <= GRID_ROWS_RST;
         window_width_ff  <= WINDOW_WIDTH_RST;
         window_height_ff <= WINDOW_HEIGHT_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_FRAME_COLS:    frame_cols_ff    <= csr_wdata;
            CSR_FRAME_ROWS:    frame_rows_ff    <= csr_wdata;
            CSR_GRID_COLS:     grid_cols_ff     <= csr_wdata[GREG_W-1:0];
            CSR_GRID_ROWS:     grid_rows_ff     <= csr_wdata[GREG_W-1:0];
            CSR_WINDOW_WIDTH:  window_width_ff  <= csr_wdata;
            CSR_WINDOW_HEIGHT: window_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamped sizes
   logic [XW-1:0] fc_x, fr_x, gc_x, gr_x, ww_x, wh_x;

   always_comb begin
      fc_x = (frame_cols_ff == '0) ? ONE_X :
             ((XW'(frame_cols_ff) > MAXF_X) ? MAXF_X : XW'(frame_cols_ff));
      fr_x = (frame_rows_ff == '0) ? ONE_X :
             ((XW'(frame_rows_ff) > MAXF_X) ? MAXF_X : XW'(frame_rows_ff));
      gc_x = (grid_cols_ff == '0) ? ONE_X :
             ((XW'(grid_cols_ff) > MAXG_X) ? MAXG_X : XW'(grid_cols_ff));
      gr_x = (grid_rows_ff == '0) ? ONE_X :
             ((XW'(grid_rows_ff) > MAXG_X) ? MAXG_X : XW'(grid_rows_ff));
      ww_x = (window_width_ff == '0) ? ONE_X : XW'(window_width_ff);
      wh_x = (window_height_ff == '0) ? ONE_X : XW'(window_height_ff);
   end

   // resync sequencer
   sync_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_RUN: ;
         ST_LOAD: begin
            state_in = ST_DIV;
            cnt_in   = '0;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIM_W - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN:  state_in = ST_RUN;
         default: state_in = ST_LOAD;
      endcase
      if (csr_we) begin
         state_in = ST_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // position counters
   logic [POS_W-1:0] x_ff, y_ff, gx_ff, gy_ff, ox_ff, oy_ff;
   logic [POS_W-1:0] x_in, y_in, gx_in, gy_in, ox_in, oy_in;
   logic [XW-1:0]    ec_ff, er_ff, ec_in, er_in;

   // dividers, one per lane
   logic [DIM_W-1:0] rem_ff [NLANE];
   logic [DIM_W-1:0] quo_ff [NLANE];
   logic [XW-1:0]    dvs    [NLANE];
   logic [DIM_W-1:0] dvd    [NLANE];

   always_comb begin
      dvs[LANE_FC] = ww_x;
      dvs[LANE_FR] = wh_x;
      dvs[LANE_X]  = ww_x;
      dvs[LANE_Y]  = wh_x;
      dvd[LANE_FC] = fc_x[DIM_W-1:0];
      dvd[LANE_FR] = fr_x[DIM_W-1:0];
      dvd[LANE_X]  = DIM_W'(x_ff);
      dvd[LANE_Y]  = DIM_W'(y_ff);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NLANE; i++) begin
         if (state_ff == ST_LOAD) begin
            rem_ff[i] <= '0;
            quo_ff[i] <= dvd[i];
         end else if (state_ff == ST_DIV) begin
            {rem_ff[i], quo_ff[i]} <= div_step(rem_ff[i], quo_ff[i], dvs[i]);
         end
      end
   end

   // stage 0: decode the position of the incoming sample
   logic          req_acc;
   logic [XW-1:0] gx_x, gy_x;
   logic          in_win, is_first, is_last, is_done;
   logic          x_wrap, y_wrap, col_step, row_step;
   s1_type        s0;

   assign req_acc = req_tvalid && req_tready;

   always_comb begin
      gx_x     = XW'(gx_ff);
      gy_x     = XW'(gy_ff);
      in_win   = (gx_x < ec_ff) && (gy_x < er_ff);
      is_first = (ox_ff == '0) && (oy_ff == '0);
      is_last  = (XW'(ox_ff) + ONE_X == ww_x) && (XW'(oy_ff) + ONE_X == wh_x);
      is_done  = (gx_x + ONE_X == ec_ff) && (gy_x + ONE_X == er_ff);
      s0.val   = req_tdata[SAMPLE_WIDTH-1] ? '0 : req_tdata[VAL_W-1:0];
      s0.win   = in_win;
      s0.first = is_first;
      s0.last  = is_last;
      s0.done  = is_done;
      s0.addr  = gx_x[GIDX_W-1:0];
      s0.grow  = gy_x[GRID_IDX_W-1:0];
      s0.gcol  = gx_x[GRID_IDX_W-1:0];
   end

   // counter update: from the dividers after resync, else one step per beat
   always_comb begin
      x_wrap   = (XW'(x_ff) + ONE_X >= fc_x);
      y_wrap   = (XW'(y_ff) + ONE_X >= fr_x);
      col_step = (XW'(ox_ff) + ONE_X == ww_x);
      row_step = (XW'(oy_ff) + ONE_X == wh_x);
      x_in  = x_ff;
      y_in  = y_ff;
      gx_in = gx_ff;
      gy_in = gy_ff;
      ox_in = ox_ff;
      oy_in = oy_ff;
      ec_in = ec_ff;
      er_in = er_ff;
      if (state_ff == ST_FIN) begin
         ec_in = (gc_x < XW'(quo_ff[LANE_FC])) ? gc_x : XW'(quo_ff[LANE_FC]);
         er_in = (gr_x < XW'(quo_ff[LANE_FR])) ? gr_x : XW'(quo_ff[LANE_FR]);
         gx_in = POS_W'(quo_ff[LANE_X]);
         ox_in = POS_W'(rem_ff[LANE_X]);
         gy_in = POS_W'(quo_ff[LANE_Y]);
         oy_in = POS_W'(rem_ff[LANE_Y]);
      end else if (req_acc) begin
         if (x_wrap) begin
            x_in  = '0;
            gx_in = '0;
            ox_in = '0;
            if (y_wrap) begin
               y_in  = '0;
               gy_in = '0;
               oy_in = '0;
            end else begin
               y_in = y_ff + POS_W'(1);
               if (row_step) begin
                  oy_in = '0;
                  gy_in = gy_ff + POS_W'(1);
               end else begin
                  oy_in = oy_ff + POS_W'(1);
               end
            end
         end else begin
            x_in = x_ff + POS_W'(1);
            if (col_step) begin
               ox_in = '0;
               gx_in = gx_ff + POS_W'(1);
            end else begin
               ox_in = ox_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff  <= '0;
         y_ff  <= '0;
         gx_ff <= '0;
         gy_ff <= '0;
         ox_ff <= '0;
         oy_ff <= '0;
         ec_ff <= '0;
         er_ff <= '0;
      end else begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         gx_ff <= gx_in;
         gy_ff <= gy_in;
         ox_ff <= ox_in;
         oy_ff <= oy_in;
         ec_ff <= ec_in;
         er_ff <= er_in;
      end
   end

   // stage 1 control and handshake
   logic   s1_valid_ff;
   s1_type s1_ff;
   logic   out_free, s1_emit, s1_go;
   logic   rsp_valid_ff;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_emit    = s1_ff.win && s1_ff.last;
   assign s1_go      = s1_valid_ff && (!s1_emit || out_free);
   assign req_tready = (state_ff == ST_RUN) && (!s1_valid_ff || s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_acc) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_ff <= s0;
      end
   end

   // row memory of running maxima, one entry per grid column
   logic [VAL_W-1:0]  win_max_mem [MAX_GRID_DIM];
   logic [VAL_W-1:0]  mem_q;
   logic              mem_wr;
   logic [VAL_W-1:0]  acc;

   assign mem_wr = s1_go && s1_ff.win;

   always_ff @(posedge clock) begin
      if (req_acc && in_win) begin
         mem_q <= win_max_mem[s0.addr];
      end
      if (mem_wr) begin
         win_max_mem[s1_ff.addr] <= acc;
      end
   end

   // last write, forwarded over a read that raced it
   logic              wr_valid_ff;
   logic [GIDX_W-1:0] wr_addr_ff;
   logic [VAL_W-1:0]  wr_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_valid_ff <= 1'b0;
      end else if (mem_wr) begin
         wr_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         wr_addr_ff <= s1_ff.addr;
         wr_data_ff <= acc;
      end
   end

   // running maximum, restarted at zero on the first sample of a window
   logic [VAL_W-1:0]          prev;
   logic [VAL_W+POOLED_W-1:0] acc_wide;

   always_comb begin
      if (s1_ff.first) begin
         prev = '0;
      end else if (wr_valid_ff && (wr_addr_ff == s1_ff.addr)) begin
         prev = wr_data_ff;
      end else begin
         prev = mem_q;
      end
      acc      = (s1_ff.val > prev) ? s1_ff.val : prev;
      acc_wide = {{POOLED_W{1'b0}}, acc};
   end

   // result register
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && s1_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_emit) begin
         rsp_data_ff <= RSP_DATA_W'({s1_ff.gcol, s1_ff.grow, acc_wide[POOLED_W-1:0]});
         rsp_last_ff <= s1_ff.done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== sv/mp2d_checker.sv =====
// ----------------------------------------------------------------------------
// mp2d_checker
// Port-level checks for the max pooling stream, bound to the top level.
// ----------------------------------------------------------------------------
module mp2d_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mp2d_pkg::RSP_DATA_W-1:0] rsp_tdata,   // pooled, grid_row, grid_col
   input logic                            rsp_tlast,
   input logic                            csr_we
);
   import mp2d_pkg::*;

   // a stalled result beat holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // a register write starts a resync that blocks the input
   a_cfg_busy : assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_tready)
      else $error("input ready right after a register write");

   // reset leaves both channels quiet
   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("channel active right after reset");

   // a fresh result comes from an accepted input sample
   a_rsp_cause : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without a matching input beat");

endmodule

bind max_pool_2d_stream mp2d_checker u_mp2d_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_we     (csr_we)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for max_pool_2d_stream. A directed table covers the
// sample extremes, all-negative windows, uncovered columns and zeroed
// registers. Then come the register extremes and randomly sized frames. Every
// accepted beat runs through a behavioral pooling predictor, and each result
// beat is compared field by field with the oldest pending window maximum.
// ----------------------------------------------------------------------------
module tb;
   import mp2d_pkg::*;

   localparam int          SAMPLE_W      = SAMPLE_WIDTH_DEF;
   localparam int unsigned RANDOM_BEATS  = 1450;
   localparam int unsigned PLANNED_BEATS = 23 + 2048 + RANDOM_BEATS;
   localparam int unsigned HOLDOFF       = 8;
   localparam int unsigned CYCLE_LIMIT   = 800000;

   typedef struct packed {
      logic [REG_W-1:0]  frame_cols;
      logic [REG_W-1:0]  frame_rows;
      logic [GREG_W-1:0] grid_cols;
      logic [GREG_W-1:0] grid_rows;
      logic [REG_W-1:0]  window_width;
      logic [REG_W-1:0]  window_height;
   } pool_cfg_t;

   typedef struct packed {
      logic [POOLED_W-1:0]   pooled;
      logic [GRID_IDX_W-1:0] grid_row;
      logic [GRID_IDX_W-1:0] grid_col;
      logic                  frame_done;
   } pool_result_t;

   typedef struct packed {
      int                  setting;
      logic [SAMPLE_W-1:0] feature;
      logic                typed;
      pool_result_t        want;
   } directed_row_t;

   // 5x4 frame, 2x2 windows, grid clipped to 2x2, rightmost column uncovered;
   // then every register zero, so each sample closes a 1x1 frame
   localparam pool_cfg_t DIRECTED_SETTINGS [2] = '{
      '{11'd5, 11'd4, 9'd2, 9'd3, 11'd2, 11'd2},
      '0
   };

   localparam directed_row_t DIRECTED_ROWS [23] = '{
      '{0, 16'h8000, 1'b0, '0},
      '{0, 16'h7FFF, 1'b0, '0},
      '{0, 16'hFFFF, 1'b0, '0},
      '{0, 16'h8001, 1'b0, '0},
      '{0, 16'h1234, 1'b0, '0},
      '{0, 16'hFFFF, 1'b0, '0},
      '{0, 16'h0001, 1'b1, '{15'h7FFF, 8'd0, 8'd0, 1'b0}},
      '{0, 16'h8000, 1'b0, '0},
      // all-negative window floors at zero
      '{0, 16'hFFFF, 1'b1, '{15'h0000, 8'd0, 8'd1, 1'b0}},
      '{0, 16'h7FFF, 1'b0, '0},
      '{0, 16'h0000, 1'b0, '0},
      '{0, 16'h0100, 1'b0, '0},
      '{0, 16'h5555, 1'b0, '0},
      '{0, 16'h2AAA, 1'b0, '0},
      '{0, 16'h7FFF, 1'b0, '0},
      '{0, 16'h00FF, 1'b0, '0},
      '{0, 16'h0080, 1'b1, '{15'h0100, 8'd1, 8'd0, 1'b0}},
      '{0, 16'h8000, 1'b0, '0},
      '{0, 16'hFFFE, 1'b1, '{15'h5555, 8'd1, 8'd1, 1'b1}},
      '{0, 16'h0001, 1'b0, '0},
      '{1, 16'h8000, 1'b1, '{15'h0000, 8'd0, 8'd0, 1'b1}},
      '{1, 16'h7FFF, 1'b1, '{15'h7FFF, 8'd0, 8'd0, 1'b1}},
      '{1, 16'h0042, 1'b1, '{15'h0042, 8'd0, 8'd0, 1'b1}}
   };

   // register extremes: widest frame with 256 grid columns, tallest with 256 rows
   localparam pool_cfg_t WIDE_SETTING = '{11'd2047, 11'd1, 9'd511, 9'd0, 11'd4, 11'd0};
   localparam pool_cfg_t TALL_SETTING = '{11'd1, 11'd2047, 9'd511, 9'd511, 11'd0, 11'd4};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [SAMPLE_W-1:0]    req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [REG_W-1:0]       csr_wdata = '0;

   // predictor state
   pool_cfg_t              live_cfg = '{11'd1024, 11'd1024, 9'd256, 9'd256, 11'd4, 11'd4};
   logic [9:0]             col_pos = '0;
   logic [9:0]             row_pos = '0;
   logic [POOLED_W-1:0]    row_max [MAX_GRID_DIM_DEF];

   pool_result_t           pending_maxima [$];
   int unsigned            beats_sent = 0;
   int unsigned            mismatch_count = 0;
   int unsigned            cycle_count = 0;
   int unsigned            sender_idle_pct = 18;
   int unsigned            receiver_idle_pct = 74;

   max_pool_2d_stream dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("max_pool_2d_stream test failed");
         $finish;
      end
   end

   task automatic note_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic int unsigned dim_or_one(input int unsigned v, input int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   // one sample through the pooling predictor; returns 1 when a window closes
   function automatic bit pool_feature(input logic [SAMPLE_W-1:0] feature,
                                       output pool_result_t r);
      logic [POOLED_W-1:0] level;
      logic [POOLED_W-1:0] acc;
      int unsigned fc, fr, ww, wh, ec, er, gx, gy, ox, oy;
      bit fires;
      level = feature[SAMPLE_W-1] ? '0 : feature[POOLED_W-1:0];
      fc = dim_or_one(live_cfg.frame_cols, MAX_FRAME_DIM_DEF);
      fr = dim_or_one(live_cfg.frame_rows, MAX_FRAME_DIM_DEF);
      ww = dim_or_one(live_cfg.window_width, 1 << REG_W);
      wh = dim_or_one(live_cfg.window_height, 1 << REG_W);
      ec = dim_or_one(live_cfg.grid_cols, MAX_GRID_DIM_DEF);
      er = dim_or_one(live_cfg.grid_rows, MAX_GRID_DIM_DEF);
      if (fc / ww < ec) ec = fc / ww;
      if (fr / wh < er) er = fr / wh;
      gx = col_pos / ww;
      gy = row_pos / wh;
      ox = col_pos % ww;
      oy = row_pos % wh;
      fires = 1'b0;
      r = '0;
      // covered part of the frame only
      if (gx < ec && gy < er) begin
         acc = (ox == 0 && oy == 0) ? '0 : row_max[gx];
         if (level > acc) acc = level;
         row_max[gx] = acc;
         if (ox == ww - 1 && oy == wh - 1) begin
            r.pooled     = acc;
            r.grid_row   = GRID_IDX_W'(gy);
            r.grid_col   = GRID_IDX_W'(gx);
            r.frame_done = (gx == ec - 1 && gy == er - 1);
            fires = 1'b1;
         end
      end
      // raster advance
      if (col_pos + 1 >= fc) begin
         col_pos = '0;
         row_pos = (row_pos + 1 >= fr) ? '0 : row_pos + 10'd1;
      end else begin
         col_pos = col_pos + 10'd1;
      end
      return fires;
   endfunction

   function automatic logic [REG_W-1:0] field_of(input pool_cfg_t c, input csr_index_type idx);
      case (idx)
         CSR_FRAME_COLS:    return c.frame_cols;
         CSR_FRAME_ROWS:    return c.frame_rows;
         CSR_GRID_COLS:     return REG_W'(c.grid_cols);
         CSR_GRID_ROWS:     return REG_W'(c.grid_rows);
         CSR_WINDOW_WIDTH:  return c.window_width;
         default:           return c.window_height;
      endcase
   endfunction

   // all six registers, one write per cycle, mirrored into the predictor
   task automatic write_registers(input pool_cfg_t c);
      csr_index_type idx;
      logic [REG_W-1:0] value;
      idx = idx.first();
      repeat (idx.num()) begin
         value = field_of(c, idx);
         csr_we    <= 1'b1;
         csr_addr  <= idx;
         csr_wdata <= value;
         @(posedge clock);
         case (idx)
            CSR_FRAME_COLS:    live_cfg.frame_cols    = value;
            CSR_FRAME_ROWS:    live_cfg.frame_rows    = value;
            CSR_GRID_COLS:     live_cfg.grid_cols     = value[GREG_W-1:0];
            CSR_GRID_ROWS:     live_cfg.grid_rows     = value[GREG_W-1:0];
            CSR_WINDOW_WIDTH:  live_cfg.window_width  = value;
            CSR_WINDOW_HEIGHT: live_cfg.window_height = value;
            default: ;
         endcase
         idx = idx.next();
      end
      csr_we <= 1'b0;
   endtask

   // stop sending, drain the pending maxima, let the row memory settle
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_maxima.size() != 0) @(posedge clock);
      repeat (HOLDOFF) @(posedge clock);
   endtask

   // one input beat with random leading gaps; predicts once accepted
   task automatic push_feature(input logic [SAMPLE_W-1:0] feature, output bit fires,
                               output pool_result_t predicted);
      case (beats_sent * 3 / PLANNED_BEATS)
         0: begin sender_idle_pct = 18; receiver_idle_pct = 74; end
         1: begin sender_idle_pct = 74; receiver_idle_pct = 18; end
         default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
      endcase
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= feature;
      do @(posedge clock); while (req_tready !== 1'b1);
      beats_sent++;
      fires = pool_feature(feature, predicted);
   endtask

   function automatic logic [SAMPLE_W-1:0] random_feature();
      case ($urandom_range(7))
         0, 1: return {1'b1, 15'($urandom)};
         2:    return SAMPLE_W'($urandom_range(255));
         3:    return 16'h7FFF;
         4:    return '0;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic pool_cfg_t random_setting();
      pool_cfg_t c;
      int unsigned gc, gr, ww, wh;
      gc = $urandom_range(1, 6);
      gr = $urandom_range(1, 5);
      ww = $urandom_range(1, 4);
      wh = $urandom_range(1, 3);
      c.grid_cols     = GREG_W'(gc);
      c.grid_rows     = GREG_W'(gr);
      c.window_width  = REG_W'(ww);
      c.window_height = REG_W'(wh);
      case ($urandom_range(9))
         // zeros, oversized grids and windows larger than the frame
         0: begin
            c.frame_cols    = REG_W'($urandom_range(12));
            c.frame_rows    = REG_W'($urandom_range(10));
            c.grid_cols     = ($urandom_range(2) == 0) ? GREG_W'($urandom_range(257, 511))
                                                       : GREG_W'($urandom_range(5));
            c.grid_rows     = GREG_W'($urandom_range(4));
            c.window_width  = REG_W'($urandom_range(5));
            c.window_height = REG_W'($urandom_range(4));
         end
         // frame no larger than the whole grid, often too small for it
         1: begin
            c.frame_cols = REG_W'($urandom_range(1, gc * ww));
            c.frame_rows = REG_W'($urandom_range(1, gr * wh));
         end
         default: begin
            c.frame_cols = REG_W'(gc * ww + $urandom_range(2));
            c.frame_rows = REG_W'(gr * wh + $urandom_range(2));
         end
      endcase
      return c;
   endfunction

   // whole frames under one register setting
   task automatic run_setting(input pool_cfg_t c, input int unsigned frames,
                              output int unsigned beats);
      bit fires;
      pool_result_t predicted;
      settle_block();
      write_registers(c);
      beats = dim_or_one(c.frame_cols, MAX_FRAME_DIM_DEF)
            * dim_or_one(c.frame_rows, MAX_FRAME_DIM_DEF) * frames;
      repeat (beats) begin
         push_feature(random_feature(), fires, predicted);
         if (fires) pending_maxima.push_back(predicted);
      end
   endtask

   // result side: random stalls, compare with the oldest pending maximum
   always @(posedge clock) begin
      pool_result_t want;
      if (rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_maxima.size() == 0) begin
            note_mismatch($sformatf("result beat %08h with nothing pending", rsp_tdata));
         end else begin
            want = pending_maxima.pop_front();
            if (rsp_tdata[POOLED_W-1:0] !== want.pooled)
               note_mismatch($sformatf("pooled got %0h want %0h",
                                       rsp_tdata[POOLED_W-1:0], want.pooled));
            if (rsp_tdata[POOLED_W +: GRID_IDX_W] !== want.grid_row)
               note_mismatch($sformatf("grid_row got %0d want %0d",
                                       rsp_tdata[POOLED_W +: GRID_IDX_W], want.grid_row));
            if (rsp_tdata[POOLED_W+GRID_IDX_W +: GRID_IDX_W] !== want.grid_col)
               note_mismatch($sformatf("grid_col got %0d want %0d",
                                       rsp_tdata[POOLED_W+GRID_IDX_W +: GRID_IDX_W],
                                       want.grid_col));
            if (rsp_tlast !== want.frame_done)
               note_mismatch($sformatf("frame_done got %b want %b",
                                       rsp_tlast, want.frame_done));
         end
      end
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   initial begin
      int current;
      int unsigned random_beats;
      int unsigned beats;
      bit fires;
      pool_result_t predicted;
      foreach (row_max[i]) row_max[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table
      current = -1;
      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].setting != current) begin
            current = DIRECTED_ROWS[i].setting;
            settle_block();
            write_registers(DIRECTED_SETTINGS[current]);
         end
         push_feature(DIRECTED_ROWS[i].feature, fires, predicted);
         if (DIRECTED_ROWS[i].typed) pending_maxima.push_back(DIRECTED_ROWS[i].want);
         else if (fires) pending_maxima.push_back(predicted);
      end

      // register extremes
      run_setting(WIDE_SETTING, 1, beats);
      run_setting(TALL_SETTING, 1, beats);

      // random settings, whole frames each
      random_beats = 0;
      while (random_beats < RANDOM_BEATS) begin
         run_setting(random_setting(), $urandom_range(1, 3), beats);
         random_beats += beats;
      end

      settle_block();
      if (mismatch_count == 0) begin
         $display("max_pool_2d_stream test passed");
      end else begin
         $display("max_pool_2d_stream test failed");
      end
      $finish;
   end

endmodule
